// ----- rtl/core/sss_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sss_pkg
// Shared types and constants for the servo sweep scheduler.
// ----------------------------------------------------------------------------
package sss_pkg;

  // Slot geometry
  localparam int NUM_SLOTS_DEF = 3;
  localparam int NUM_DRIVERS   = 2;

  // Angle limits (degrees)
  localparam logic [7:0] ANGLE_FULL   = 8'd180;
  localparam logic [7:0] WOBBLE_LO    = 8'd45;
  localparam logic [7:0] WOBBLE_HI    = 8'd135;
  localparam logic [7:0] WOBBLE_START = 8'd90;

  // floor(x / 180) == (x * DIV180_MUL) >> DIV180_SHIFT, exact for x < 2**20
  localparam int          DIV180_SHIFT = 28;
  localparam logic [20:0] DIV180_MUL   = 21'd1491309;

  // Configuration register map
  localparam int          CFG_AW = 5;
  localparam logic [2:0] REG_DUTY_MIN   = 3'd0;
  localparam logic [2:0] REG_DUTY_MAX   = 3'd1;
  localparam logic [2:0] REG_UPDATE     = 3'd2;
  localparam logic [2:0] REG_MODE_SWAP  = 3'd3;
  localparam logic [2:0] REG_SLOT0_CHAN = 3'd4;
  localparam logic [2:0] REG_SLOT1_CHAN = 3'd5;
  localparam logic [2:0] REG_SLOT2_CHAN = 3'd6;

  // Register reset values
  localparam logic [11:0] DUTY_MIN_RST   = 12'd90;
  localparam logic [11:0] DUTY_MAX_RST   = 12'd500;
  localparam logic [15:0] UPDATE_RST     = 16'd10;
  localparam logic [15:0] MODE_SWAP_RST  = 16'd10000;
  localparam logic [4:0]  SLOT0_CHAN_RST = 5'd0;
  localparam logic [4:0]  SLOT1_CHAN_RST = 5'd2;
  localparam logic [4:0]  SLOT2_CHAN_RST = 5'd16;

  typedef struct packed {
    logic [11:0] duty_min;
    logic [11:0] duty_max;
    logic [15:0] update_period_ms;
    logic [15:0] mode_swap_ms;
    logic [4:0]  slot0_channel;
    logic [4:0]  slot1_channel;
    logic [4:0]  slot2_channel;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic start;  // mode timer and slot counters advance
    logic mul;    // angle * duty span
    logic div;    // divide by 180
    logic emit;   // load result, advance angle
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic fire_sel;  // selected slot fires this tick
    logic out_free;  // result register can take an item
  } status_t;

  // Per-slot reset state
  function automatic logic [7:0] slot_angle_rst(input int k);
    logic [7:0] a;
    a = 8'd0;
    if (k == 1) a = ANGLE_FULL;
    if (k == 2) a = WOBBLE_START;
    return a;
  endfunction

  function automatic logic slot_neg_rst(input int k);
    return (k == 1);
  endfunction

  function automatic logic slot_wobble_rst(input int k);
    return (k == 2);
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/sss_tick_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sss_tick_if
// Millisecond tick channel.
// ----------------------------------------------------------------------------
interface sss_tick_if;
  logic valid;
  logic ready;
  logic tick;

  modport source (output valid, output tick, input ready);
  modport sink   (input valid, input tick, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/sss_result_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sss_result_if
// PWM update channel: one item per servo slot update.
// ----------------------------------------------------------------------------
interface sss_result_if;
  logic        valid;
  logic        ready;
  logic        driver_index;
  logic [3:0]  channel;
  logic [11:0] duty;
  logic        last;

  modport source (output valid, output driver_index, output channel, output duty,
                  output last, input ready);
  modport sink   (input valid, input driver_index, input channel, input duty,
                  input last, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/sss_regs.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sss_regs
// APB configuration register file.
// ----------------------------------------------------------------------------
module sss_regs (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [sss_pkg::CFG_AW-1:0] paddr,
  input  wire logic [31:0]               pwdata,
  output logic      [31:0]               prdata,
  output logic                           pready,
  output sss_pkg::cfg_t                  cfg
);
  import sss_pkg::*;

  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[4:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.duty_min         <= DUTY_MIN_RST;
      cfg.duty_max         <= DUTY_MAX_RST;
      cfg.update_period_ms <= UPDATE_RST;
      cfg.mode_swap_ms     <= MODE_SWAP_RST;
      cfg.slot0_channel    <= SLOT0_CHAN_RST;
      cfg.slot1_channel    <= SLOT1_CHAN_RST;
      cfg.slot2_channel    <= SLOT2_CHAN_RST;
    end else if (wr) begin
      unique case (idx)
        REG_DUTY_MIN:   cfg.duty_min         <= pwdata[11:0];
        REG_DUTY_MAX:   cfg.duty_max         <= pwdata[11:0];
        REG_UPDATE:     cfg.update_period_ms <= pwdata[15:0];
        REG_MODE_SWAP:  cfg.mode_swap_ms     <= pwdata[15:0];
        REG_SLOT0_CHAN: cfg.slot0_channel    <= pwdata[4:0];
        REG_SLOT1_CHAN: cfg.slot1_channel    <= pwdata[4:0];
        REG_SLOT2_CHAN: cfg.slot2_channel    <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (idx)
      REG_DUTY_MIN:   prdata = {20'd0, cfg.duty_min};
      REG_DUTY_MAX:   prdata = {20'd0, cfg.duty_max};
      REG_UPDATE:     prdata = {16'd0, cfg.update_period_ms};
      REG_MODE_SWAP:  prdata = {16'd0, cfg.mode_swap_ms};
      REG_SLOT0_CHAN: prdata = {27'd0, cfg.slot0_channel};
      REG_SLOT1_CHAN: prdata = {27'd0, cfg.slot1_channel};
      REG_SLOT2_CHAN: prdata = {27'd0, cfg.slot2_channel};
      default:        prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/core/sss_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sss_ctrl
// Sequencer: per tick, a start state, then one visit per slot; a firing slot
// also passes multiply, divide and emit; emit waits for the result register.
// ----------------------------------------------------------------------------
module sss_ctrl #(
  parameter int NUM_SLOTS = sss_pkg::NUM_SLOTS_DEF,
  parameter int SW        = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire logic             in_tick,
  output logic                  in_ready,
  input  wire sss_pkg::status_t stat,
  output sss_pkg::cmd_t         cmd,
  output logic      [SW-1:0]    slot
);
  import sss_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_START, S_SEL, S_MUL, S_DIV, S_EMIT
  } state_t;

  localparam logic [SW-1:0] LAST_SLOT = SW'(NUM_SLOTS - 1);

  state_t state;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd       = '0;
    cmd.start = (state == S_START);
    cmd.mul   = (state == S_MUL);
    cmd.div   = (state == S_DIV);
    cmd.emit  = (state == S_EMIT) && stat.out_free;
  end

  // State and slot index
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      slot  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_tick) state <= S_START;
        end
        S_START: begin
          slot  <= '0;
          state <= S_SEL;
        end
        S_SEL: begin
          if (stat.fire_sel) begin
            state <= S_MUL;
          end else if (slot == LAST_SLOT) begin
            state <= S_IDLE;
          end else begin
            slot <= slot + 1'b1;
          end
        end
        S_MUL: state <= S_DIV;
        S_DIV: state <= S_EMIT;
        S_EMIT: begin
          if (stat.out_free) begin
            if (slot == LAST_SLOT) begin
              state <= S_IDLE;
            end else begin
              slot  <= slot + 1'b1;
              state <= S_SEL;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/sss_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sss_dp
// Slot state, mode timer, duty arithmetic and the result register.
// ----------------------------------------------------------------------------
module sss_dp #(
  parameter int NUM_SLOTS = sss_pkg::NUM_SLOTS_DEF,
  parameter int SW        = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire sss_pkg::cfg_t   cfg,
  input  wire sss_pkg::cmd_t   cmd,
  input  wire logic [SW-1:0]   slot,
  output sss_pkg::status_t     stat,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic                 out_driver_index,
  output logic      [3:0]      out_channel,
  output logic      [11:0]     out_duty,
  output logic                 out_last
);
  import sss_pkg::*;

  // Slot state, one lane per slot
  logic [7:0]  angle   [NUM_SLOTS];
  logic        neg     [NUM_SLOTS];
  logic        wobble  [NUM_SLOTS];
  logic [15:0] elapsed [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] fire;

  logic [15:0] mode_elapsed;
  logic        mode_phase;

  // Counter updates for the start cycle
  logic [15:0] period;
  logic [15:0] mode_inc;
  logic        mode_swap;
  logic [15:0] elapsed_inc [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] fire_next;

  assign period    = (cfg.update_period_ms == 16'd0) ? 16'd1 : cfg.update_period_ms;
  assign mode_inc  = (mode_elapsed == 16'hFFFF) ? mode_elapsed : mode_elapsed + 16'd1;
  assign mode_swap = (mode_inc > cfg.mode_swap_ms);

  always_comb begin
    for (int k = 0; k < NUM_SLOTS; k++) begin
      elapsed_inc[k] = (elapsed[k] == 16'hFFFF) ? elapsed[k] : elapsed[k] + 16'd1;
      fire_next[k]   = (elapsed_inc[k] >= period);
    end
  end

  // Angle advance of the selected slot
  logic [7:0]        sel_angle;
  logic              sel_neg;
  logic              sel_wobble;
  logic signed [9:0] trial;
  logic signed [9:0] lo;
  logic signed [9:0] hi;
  logic              flip;
  logic              neg_new;
  logic [7:0]        angle_new;

  assign sel_angle  = angle[slot];
  assign sel_neg    = neg[slot];
  assign sel_wobble = wobble[slot];
  assign trial      = signed'({2'b00, sel_angle}) + (sel_neg ? -10'sd1 : 10'sd1);
  assign lo         = sel_wobble ? signed'({2'b00, WOBBLE_LO}) : 10'sd0;
  assign hi         = sel_wobble ? signed'({2'b00, WOBBLE_HI})
                                 : signed'({2'b00, ANGLE_FULL});
  assign flip       = (trial < lo) || (trial > hi);
  assign neg_new    = sel_neg ^ flip;
  assign angle_new  = neg_new ? sel_angle - 8'd1 : sel_angle + 8'd1;

  // Slot and timer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_SLOTS; k++) begin
        angle[k]   <= slot_angle_rst(k);
        neg[k]     <= slot_neg_rst(k);
        wobble[k]  <= slot_wobble_rst(k);
        elapsed[k] <= 16'd0;
      end
      fire         <= '0;
      mode_elapsed <= 16'd0;
      mode_phase   <= 1'b0;
    end else if (cmd.start) begin
      for (int k = 0; k < NUM_SLOTS; k++) begin
        elapsed[k] <= fire_next[k] ? 16'd0 : elapsed_inc[k];
      end
      fire <= fire_next;
      if (mode_swap) begin
        mode_elapsed <= 16'd0;
        mode_phase   <= ~mode_phase;
        wobble[0]    <= ~mode_phase;
        angle[0]     <= mode_phase ? 8'd0 : WOBBLE_START;
      end else begin
        mode_elapsed <= mode_inc;
      end
    end else if (cmd.emit) begin
      angle[slot] <= angle_new;
      neg[slot]   <= neg_new;
    end
  end

  // Duty: min + angle * (max - min) / 180, truncated toward zero
  logic signed [12:0] span;
  logic signed [21:0] prod;
  logic signed [21:0] prod_r;
  logic [21:0]        prod_abs;
  logic [40:0]        quot_full;
  logic [12:0]        quot;
  logic               quot_neg;
  logic [11:0]        duty_new;

  assign span      = signed'({1'b0, cfg.duty_max}) - signed'({1'b0, cfg.duty_min});
  assign prod      = signed'({1'b0, sel_angle}) * span;
  assign prod_abs  = prod_r[21] ? 22'(-prod_r) : 22'(prod_r);
  assign quot_full = prod_abs[19:0] * DIV180_MUL;
  assign duty_new  = cfg.duty_min + (quot_neg ? 12'(-quot) : quot[11:0]);

  always_ff @(posedge clk) begin
    if (cmd.mul) prod_r <= prod;
    if (cmd.div) begin
      quot     <= quot_full[DIV180_SHIFT +: 13];
      quot_neg <= prod_r[21];
    end
  end

  // Channel id and last flag of the selected slot
  logic [4:0] chan_id;
  logic       later_fire;

  always_comb begin
    if (slot == SW'(0))           chan_id = cfg.slot0_channel;
    else if (slot == SW'(1))      chan_id = cfg.slot1_channel;
    else if (slot == SW'(2))      chan_id = cfg.slot2_channel;
    else                          chan_id = 5'(slot);
    later_fire = 1'b0;
    for (int k = 0; k < NUM_SLOTS; k++) begin
      if (SW'(k) > slot && fire[k]) later_fire = 1'b1;
    end
  end

  // Result register
  assign stat.out_free = !out_valid || out_ready;
  assign stat.fire_sel = fire[slot];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_driver_index <= (NUM_DRIVERS > 1) ? chan_id[4] : 1'b0;
      out_channel      <= chan_id[3:0];
      out_duty         <= duty_new;
      out_last         <= !later_fire;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/servo_sweep_scheduler.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// servo_sweep_scheduler
// Millisecond-driven servo sweep: per tick, steps the mode timer and each
// slot's update counter and emits a PWM duty update for every slot that fires.
// ----------------------------------------------------------------------------
// Sequence: an accepted tick passes the start state, then each slot in order;
//   a firing slot also passes multiply, divide and emit, loading its update
//   into the result register; emit waits while that register is full.
// Occupancy: a tick holds the sequencer until every slot is visited, an idle
//   item does not; the shared duty multiply/divide path serves one slot at a time.
// Reset: synchronous, active high; loads the register defaults and slot start
//   states, no clearing pass.
module servo_sweep_scheduler #(
  parameter int NUM_SLOTS = sss_pkg::NUM_SLOTS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  sss_tick_if.sink                        tick_ch,
  sss_result_if.source                    result_ch,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [sss_pkg::CFG_AW-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic      [31:0]                prdata,
  output logic                            pready
);
  import sss_pkg::*;

  localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  cfg_t          cfg;
  cmd_t          cmd;
  status_t       stat;
  logic [SW-1:0] slot;

  sss_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sss_ctrl #(
    .NUM_SLOTS (NUM_SLOTS),
    .SW        (SW)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (tick_ch.valid),
    .in_tick  (tick_ch.tick),
    .in_ready (tick_ch.ready),
    .stat     (stat),
    .cmd      (cmd),
    .slot     (slot)
  );

  sss_dp #(
    .NUM_SLOTS (NUM_SLOTS),
    .SW        (SW)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .cmd              (cmd),
    .slot             (slot),
    .stat             (stat),
    .out_valid        (result_ch.valid),
    .out_ready        (result_ch.ready),
    .out_driver_index (result_ch.driver_index),
    .out_channel      (result_ch.channel),
    .out_duty         (result_ch.duty),
    .out_last         (result_ch.last)
  );

endmodule
`default_nettype wire

// ----- tb/sss_update_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sss_update_checker
// Watches the tick, result and register ports of the servo sweep scheduler.
// Keeps its own copy of the slot state and the registers, works out the
// PWM updates that every accepted tick must cause, and compares each accepted
// result with the oldest update still due.
// ----------------------------------------------------------------------------
module sss_update_checker (
  input  wire logic                       clk,
  input  wire logic                       rst,
  sss_tick_if                             tick_mon,
  sss_result_if                           result_mon,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic                       pready,
  input  wire logic [sss_pkg::CFG_AW-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output int                              pending,
  output int                              errors
);
  import sss_pkg::*;

  localparam int SLOTS         = NUM_SLOTS_DEF;
  localparam int SWEEP_TOP     = 180;
  localparam int WOBBLE_BOTTOM = 45;
  localparam int WOBBLE_TOP    = 135;
  localparam int WOBBLE_CENTER = 90;
  localparam int SHOW_LIMIT    = 10;

  typedef struct packed {
    logic        driver_index;
    logic [3:0]  channel;
    logic [11:0] duty;
    logic        last;
  } pwm_update_t;

  pwm_update_t updates_due[$];

  // Shadow registers and slot state
  cfg_t        regs;
  logic [7:0]  angle[SLOTS];
  logic        step_down[SLOTS];
  logic        wobble[SLOTS];
  logic [15:0] slot_ms[SLOTS];
  logic [15:0] mode_ms;
  logic        mode_phase;
  int          result_no;

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic logic [4:0] channel_id(input int k);
    logic [4:0] id;
    case (k)
      0:       id = regs.slot0_channel;
      1:       id = regs.slot1_channel;
      2:       id = regs.slot2_channel;
      default: id = k[4:0];
    endcase
    return id;
  endfunction

  // duty_min + angle * span / 180, truncated toward zero, kept to 12 bits
  function automatic logic [11:0] duty_for(input logic [7:0] a);
    int span;
    int d;
    span = int'(regs.duty_max) - int'(regs.duty_min);
    d = int'(regs.duty_min) + (int'(a) * span) / SWEEP_TOP;
    return d[11:0];
  endfunction

  // Bounce inside the slot's range, turning the step first when needed
  task automatic step_slot(input int k);
    int lo;
    int hi;
    int nxt;
    lo = wobble[k] ? WOBBLE_BOTTOM : 0;
    hi = wobble[k] ? WOBBLE_TOP : SWEEP_TOP;
    nxt = int'(angle[k]) + (step_down[k] ? -1 : 1);
    if (nxt < lo || nxt > hi) begin
      step_down[k] = !step_down[k];
    end
    angle[k] = angle[k] + (step_down[k] ? 8'hFF : 8'd1);
  endtask

  // One millisecond: mode timer first, then each slot in order
  task automatic predict_tick();
    pwm_update_t batch[SLOTS];
    logic [15:0] period;
    logic [4:0]  id;
    int          n;
    n = 0;
    mode_ms = sat_inc(mode_ms);
    if (mode_ms > regs.mode_swap_ms) begin
      mode_ms = 16'd0;
      if (!mode_phase) begin
        wobble[0]  = 1'b1;
        angle[0]   = WOBBLE_CENTER[7:0];
        mode_phase = 1'b1;
      end else begin
        wobble[0]  = 1'b0;
        angle[0]   = 8'd0;
        mode_phase = 1'b0;
      end
    end
    period = (regs.update_period_ms == 16'd0) ? 16'd1 : regs.update_period_ms;
    for (int k = 0; k < SLOTS; k++) begin
      slot_ms[k] = sat_inc(slot_ms[k]);
      if (slot_ms[k] >= period) begin
        id = channel_id(k);
        slot_ms[k] = 16'd0;
        batch[n].driver_index = id[4];
        batch[n].channel      = id[3:0];
        batch[n].duty         = duty_for(angle[k]);
        batch[n].last         = 1'b0;
        n++;
        step_slot(k);
      end
    end
    for (int j = 0; j < n; j++) begin
      if (j == n - 1) begin
        batch[j].last = 1'b1;
      end
      updates_due.push_back(batch[j]);
    end
  endtask

  task automatic shadow_write(input logic [2:0] idx, input logic [31:0] value);
    case (idx)
      REG_DUTY_MIN:   regs.duty_min         = value[11:0];
      REG_DUTY_MAX:   regs.duty_max         = value[11:0];
      REG_UPDATE:     regs.update_period_ms = value[15:0];
      REG_MODE_SWAP:  regs.mode_swap_ms     = value[15:0];
      REG_SLOT0_CHAN: regs.slot0_channel    = value[4:0];
      REG_SLOT1_CHAN: regs.slot1_channel    = value[4:0];
      REG_SLOT2_CHAN: regs.slot2_channel    = value[4:0];
      default: ;
    endcase
  endtask

  // Sample everything at the rising edge; results first, then new work
  always @(posedge clk) begin
    pwm_update_t got;
    pwm_update_t want;
    if (rst) begin
      updates_due.delete();
      regs.duty_min         = 12'd90;
      regs.duty_max         = 12'd500;
      regs.update_period_ms = 16'd10;
      regs.mode_swap_ms     = 16'd10000;
      regs.slot0_channel    = 5'd0;
      regs.slot1_channel    = 5'd2;
      regs.slot2_channel    = 5'd16;
      for (int k = 0; k < SLOTS; k++) begin
        angle[k]     = 8'd0;
        step_down[k] = 1'b0;
        wobble[k]    = 1'b0;
        slot_ms[k]   = 16'd0;
      end
      angle[1]     = SWEEP_TOP[7:0];
      step_down[1] = 1'b1;
      angle[2]     = WOBBLE_CENTER[7:0];
      wobble[2]    = 1'b1;
      mode_ms      = 16'd0;
      mode_phase   = 1'b0;
      errors       = 0;
      result_no    = 0;
    end else begin
      if (result_mon.valid && result_mon.ready) begin
        got.driver_index = result_mon.driver_index;
        got.channel      = result_mon.channel;
        got.duty         = result_mon.duty;
        got.last         = result_mon.last;
        if (updates_due.size() == 0) begin
          if (errors < SHOW_LIMIT) begin
            $display("result %0d arrived with nothing due: drv %0d ch %0d duty %0d last %0d",
                     result_no, got.driver_index, got.channel, got.duty, got.last);
          end
          errors++;
        end else begin
          want = updates_due.pop_front();
          if (got.driver_index !== want.driver_index || got.channel !== want.channel ||
              got.duty !== want.duty || got.last !== want.last) begin
            if (errors < SHOW_LIMIT) begin
              $display("result %0d differs: want drv %0d ch %0d duty %0d last %0d",
                       result_no, want.driver_index, want.channel, want.duty, want.last);
              $display("            got  drv %0d ch %0d duty %0d last %0d",
                       got.driver_index, got.channel, got.duty, got.last);
            end
            errors++;
          end
        end
        result_no++;
      end
      if (tick_mon.valid && tick_mon.ready && tick_mon.tick) begin
        predict_tick();
      end
      if (psel && penable && pwrite && pready) begin
        shadow_write(paddr[sss_pkg::CFG_AW-1:2], pwdata);
      end
    end
    pending = updates_due.size();
  end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives ticks and register writes into the servo sweep scheduler under
// changing backpressure and register settings; an update checker beside the
// block predicts every PWM update; the bench then says whether any differed.
// ----------------------------------------------------------------------------
module testbench;
  import sss_pkg::*;

  localparam logic [2:0] REG_UNMAPPED = 3'd7;
  localparam int CHUNKS      = 9;
  localparam int CHUNK_ITEMS = 48;
  localparam int DRAIN_CYCLES = 20;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;
  int                send_idle_pct;
  int                recv_idle_pct;
  int                pending;
  int                errors;

  sss_tick_if   tick_ch ();
  sss_result_if result_ch ();

  servo_sweep_scheduler uut (
    .clk       (clk),
    .rst       (rst),
    .tick_ch   (tick_ch),
    .result_ch (result_ch),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  sss_update_checker update_check (
    .clk        (clk),
    .rst        (rst),
    .tick_mon   (tick_ch),
    .result_mon (result_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pending    (pending),
    .errors     (errors)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #3_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Receiver backpressure
  always @(negedge clk) begin
    result_ch.ready = ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // One tick item, with random gaps before it; called at a falling edge
  task automatic send_tick(input logic t);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      tick_ch.valid = 1'b0;
      @(negedge clk);
    end
    tick_ch.valid = 1'b1;
    tick_ch.tick  = t;
    @(posedge clk);
    while (!tick_ch.ready) @(posedge clk);
    @(negedge clk);
    tick_ch.valid = 1'b0;
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Wait for all updates, then for a tick that fires nothing to finish
  task automatic settle();
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic load_setting(input logic [31:0] dmin, input logic [31:0] dmax,
                              input logic [31:0] period, input logic [31:0] swap,
                              input logic [31:0] c0, input logic [31:0] c1,
                              input logic [31:0] c2);
    settle();
    cfg_write(REG_DUTY_MIN, dmin);
    cfg_write(REG_DUTY_MAX, dmax);
    cfg_write(REG_UPDATE, period);
    cfg_write(REG_MODE_SWAP, swap);
    cfg_write(REG_SLOT0_CHAN, c0);
    cfg_write(REG_SLOT1_CHAN, c1);
    cfg_write(REG_SLOT2_CHAN, c2);
  endtask

  function automatic logic [31:0] pick_duty();
    logic [31:0] d;
    case ($urandom_range(0, 3))
      0:       d = 32'd0;
      1:       d = 32'd4095;
      default: d = $urandom_range(0, 4095);
    endcase
    // junk above the register width must be dropped
    return ($urandom & 32'hFFFF_F000) | d;
  endfunction

  // Mostly short periods so the slots sweep far; rare extremes
  task automatic random_setting();
    logic [31:0] period;
    logic [31:0] swap;
    case ($urandom_range(0, 9))
      0:       period = 32'd0;
      1:       period = 32'd65535;
      2:       period = $urandom_range(5, 20);
      default: period = $urandom_range(1, 3);
    endcase
    case ($urandom_range(0, 9))
      0:       swap = 32'd0;
      1:       swap = 32'd65535;
      2:       swap = $urandom_range(100, 400);
      default: swap = $urandom_range(1, 40);
    endcase
    load_setting(pick_duty(), pick_duty(),
                 ($urandom & 32'hFFFF_0000) | period,
                 ($urandom & 32'hFFFF_0000) | swap,
                 ($urandom & 32'hFFFF_FFE0) | $urandom_range(0, 31),
                 ($urandom & 32'hFFFF_FFE0) | $urandom_range(0, 31),
                 ($urandom & 32'hFFFF_FFE0) | $urandom_range(0, 31));
  endtask

  initial begin
    rst             = 1'b1;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    tick_ch.valid   = 1'b0;
    tick_ch.tick    = 1'b0;
    result_ch.ready = 1'b0;
    send_idle_pct   = 10;
    recv_idle_pct   = 70;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // Idle item and plain ticks at the reset setting
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b1);

    // Full duty span, every slot fires each tick, mode flips every other tick
    load_setting(32'd0, 32'd4095, 32'd1, 32'd1, 32'd31, 32'd15, 32'd16);
    repeat (6) send_tick(1'b1);
    send_tick(1'b0);

    // Falling duty, zero period, mode flips on every tick
    load_setting(32'd4095, 32'd0, 32'd0, 32'd0, 32'd0, 32'd17, 32'd1);
    repeat (5) send_tick(1'b1);

    // Write to an unmapped index is dropped; swap limit at its top, so no mode flip
    settle();
    cfg_write(REG_UNMAPPED, 32'hFFFF_FFFF);
    load_setting(32'd90, 32'd500, 32'd3, 32'd65535, 32'd2, 32'd30, 32'd16);
    repeat (7) send_tick(1'b1);

    // Random phases under three backpressure patterns
    for (int chunk = 0; chunk < CHUNKS; chunk++) begin
      if (chunk < 3) begin
        send_idle_pct = 10;
        recv_idle_pct = 70;
      end else if (chunk < 6) begin
        send_idle_pct = 70;
        recv_idle_pct = 10;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      random_setting();
      for (int i = 0; i < CHUNK_ITEMS; i++) begin
        // hold the sender until the block has drained
        if (i == CHUNK_ITEMS / 2) begin
          while (pending != 0) @(negedge clk);
        end
        send_tick($urandom_range(0, 99) < 88);
      end
    end

    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
